FILE: design/rwc_pkg.sv
package rwc_pkg;

    localparam int unsigned MAX_SCREEN = 2048;
    localparam int unsigned MAX_TEXW   = 1024;
    localparam int unsigned MAX_TEXL   = 10;
    localparam int unsigned DIR_FRAC   = 14;

    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_TEXTURE_WIDTH = 2'd1;
    localparam logic [1:0] CFG_TEXTURE_LOG2  = 2'd2;

    localparam logic [1:0] REGION_CEILING = 2'd0;
    localparam logic [1:0] REGION_WALL    = 2'd1;
    localparam logic [1:0] REGION_FLOOR   = 2'd2;

    localparam logic [1:0] FACE_EAST  = 2'd0;
    localparam logic [1:0] FACE_WEST  = 2'd1;
    localparam logic [1:0] FACE_SOUTH = 2'd2;
    localparam logic [1:0] FACE_NORTH = 2'd3;

    // effective configuration, already clamped
    typedef struct packed {
        logic [11:0] height;
        logic [10:0] width;
        logic [3:0]  tex_log2;
    } cfg_t;

    // one queued item, dir and player already picked by hit side
    typedef struct packed {
        logic        is_row;
        logic [11:0] column;
        logic [31:0] wall_dist;
        logic        side;
        logic        sxp;
        logic        syp;
        logic [15:0] dir;
        logic [23:0] player;
    } cmd_t;

    // per-column values handed from setup to the row generator
    typedef struct packed {
        logic [11:0] column;
        logic [10:0] top;
        logic [10:0] bottom;
        logic [1:0]  face;
        logic [9:0]  tex_col;
    } col_t;

endpackage

FILE: design/rwc_if.sv
interface rwc_item_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [11:0] column;
    logic [31:0] wall_distance;
    logic        hit_side;
    logic        step_x_positive;
    logic        step_y_positive;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [23:0] player_x;
    logic [23:0] player_y;

    modport source (
        output valid, mode, column, wall_distance, hit_side, step_x_positive,
               step_y_positive, dir_x, dir_y, player_x, player_y,
        input  ready
    );
    modport sink (
        input  valid, mode, column, wall_distance, hit_side, step_x_positive,
               step_y_positive, dir_x, dir_y, player_x, player_y,
        output ready
    );
endinterface

interface rwc_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_column;
    logic [10:0] row;
    logic [1:0]  region;
    logic [1:0]  face;
    logic [9:0]  tex_col;
    logic [9:0]  tex_row;
    logic        last_row;

    modport source (
        output valid, out_column, row, region, face, tex_col, tex_row, last_row,
        input  ready
    );
    modport sink (
        input  valid, out_column, row, region, face, tex_col, tex_row, last_row,
        output ready
    );
endinterface

interface rwc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [11:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

FILE: design/rwc_front.sv
module rwc_front (
    input  logic          clk,
    input  logic          rst_n,
    rwc_item_if.sink      item,
    output rwc_pkg::cmd_t head,
    output logic          head_valid,
    input  logic          head_pop
);
    import rwc_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    cmd_t       cmd;
    logic       push;
    logic       pop;

    always_comb
    begin
        cmd.is_row    = item.mode;
        cmd.column    = item.column;
        cmd.wall_dist = item.wall_distance;
        cmd.side      = item.hit_side;
        cmd.sxp       = item.step_x_positive;
        cmd.syp       = item.step_y_positive;
        cmd.dir       = item.hit_side ? item.dir_x : item.dir_y;
        cmd.player    = item.hit_side ? item.player_x : item.player_y;
    end

    assign item.ready = (count_reg != 2'd2);
    assign push       = item.valid && item.ready;
    assign pop        = head_pop && head_valid;
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cmd;
    end

endmodule

FILE: design/rwc_setup.sv
module rwc_setup #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  rwc_pkg::cmd_t              cmd,
    input  rwc_pkg::cfg_t              cfg,
    output logic                       busy,
    output logic                       load,
    output rwc_pkg::col_t              col,
    output logic [FRACTION_BITS+10:0]  step,
    output logic [FRACTION_BITS+9:0]   pos
);
    import rwc_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int DW = 12 + F;
    localparam int SW = F + 11;
    localparam int PW = F + 10;
    localparam int PL = DIR_FRAC + F;
    localparam int CW = $clog2(DW + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIVH = 6'b000010,
        S_SPAN = 6'b000100,
        S_DIVS = 6'b001000,
        S_MUL  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] cnt_reg;
    cmd_t          cmd_reg;
    logic [DW-1:0] num_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   den_reg;
    logic [47:0]   prod_reg;
    logic [10:0]   tx_reg;
    logic [10:0]   top_reg;
    logic [10:0]   bot_reg;
    logic [PW-1:0] mula_reg;
    logic [PW-1:0] mulb_reg;
    logic [PW-1:0] acc_reg;
    logic [SW-1:0] step_reg;

    logic [32:0]   rem_sh;
    logic          ge;
    logic [32:0]   rem_sub;
    logic [31:0]   rem_new;
    logic [DW-1:0] num_new;
    logic [63:0]   q64;
    logic [31:0]   hei;
    logic [30:0]   half_w;
    logic [10:0]   half_h;
    logic [31:0]   bot_sum;
    logic [11:0]   h_m1;
    logic [63:0]   pos_rows;
    logic [16:0]   mag17;
    logic [PL-1:0] sprod;
    logic [F-1:0]  frac;
    logic [F+10:0] txp;
    logic          mirror;
    logic [10:0]   tcol11;
    logic          div_last;
    logic          mul_last;

    // restoring divider, one quotient bit per cycle
    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[DW-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
        rem_new = ge ? rem_sub[31:0] : rem_sh[31:0];
        num_new = {num_reg[DW-2:0], ge};
    end

    // wall height from first quotient, saturating
    always_comb
    begin
        q64     = 64'(num_reg);
        hei     = ((cmd_reg.wall_dist == 32'd0) || (q64 > 64'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                          : q64[31:0];
        half_w  = hei[31:1];
        half_h  = cfg.height[11:1];
        h_m1    = cfg.height - 12'd1;
        bot_sum = {1'b0, half_w} + {21'd0, half_h};
        if ({20'd0, h_m1} < bot_sum)
            bot_sum = {20'd0, h_m1};
        pos_rows = (half_w >= {20'd0, half_h}) ? 64'(half_w - {20'd0, half_h}) : 64'd0;
    end

    // texture column from the hit fraction
    always_comb
    begin
        mag17  = cmd_reg.dir[15] ? (17'h10000 - {1'b0, cmd_reg.dir}) : {1'b0, cmd_reg.dir};
        sprod  = cmd_reg.dir[15] ? (PL'(0) - prod_reg[PL-1:0]) : prod_reg[PL-1:0];
        frac   = cmd_reg.player[F-1:0] + sprod[PL-1:DIR_FRAC];
        txp    = (F+11)'(frac) * (F+11)'(cfg.width);
        mirror = (!cmd_reg.side && cmd_reg.sxp) || (cmd_reg.side && !cmd_reg.syp);
        tcol11 = mirror ? (cfg.width - tx_reg - 11'd1) : tx_reg;
    end

    assign div_last = (cnt_reg == CW'(DW - 1));
    assign mul_last = (cnt_reg == CW'(PW - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (start)
                        state_reg <= S_DIVH;
                end
                S_DIVH:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (div_last)
                        state_reg <= S_SPAN;
                end
                S_SPAN:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIVS;
                end
                S_DIVS:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (div_last)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (mul_last)
                        state_reg <= S_DONE;
                end
                S_DONE:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= {16'd0, cmd_reg.wall_dist} * {32'd0, mag17[15:0]};
        tx_reg   <= txp[F+10:F];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_reg <= cmd;
                    num_reg <= DW'(cfg.height) << F;
                    rem_reg <= '0;
                    den_reg <= cmd.wall_dist;
                end
            end
            S_DIVH, S_DIVS:
            begin
                num_reg <= num_new;
                rem_reg <= rem_new;
                if (state_reg == S_DIVS && div_last)
                begin
                    step_reg <= num_new[SW-1:0];
                    mulb_reg <= num_new[PW-1:0];
                    acc_reg  <= '0;
                end
            end
            S_SPAN:
            begin
                top_reg  <= (half_w >= {20'd0, half_h}) ? 11'd0 : (half_h - half_w[10:0]);
                bot_reg  <= bot_sum[10:0];
                mula_reg <= pos_rows[PW-1:0];
                num_reg  <= DW'(1) << (6'(cfg.tex_log2) + 6'(F));
                rem_reg  <= '0;
                den_reg  <= (hei == 32'd0) ? 32'd1 : hei;
            end
            S_MUL:
            begin
                // shift-add start position, modulo the bits that reach the texture row
                if (mula_reg[0])
                    acc_reg <= acc_reg + mulb_reg;
                mula_reg <= mula_reg >> 1;
                mulb_reg <= mulb_reg << 1;
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign load = (state_reg == S_DONE);

    always_comb
    begin
        col.column  = cmd_reg.column;
        col.top     = top_reg;
        col.bottom  = bot_reg;
        col.face    = cmd_reg.side ? (cmd_reg.syp ? FACE_SOUTH : FACE_NORTH)
                                   : (cmd_reg.sxp ? FACE_EAST : FACE_WEST);
        col.tex_col = tcol11[9:0];
    end

    assign step = step_reg;
    assign pos  = acc_reg;

endmodule

FILE: design/rwc_rows.sv
module rwc_rows #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  rwc_pkg::col_t             col,
    input  logic [FRACTION_BITS+10:0] step,
    input  logic [FRACTION_BITS+9:0]  pos,
    input  rwc_pkg::cfg_t             cfg,
    input  logic                      row_req,
    output logic                      row_pop,
    rwc_result_if.source              result
);
    import rwc_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int PW = F + 10;

    col_t          col_reg;
    logic [F+10:0] step_reg;
    logic [PW-1:0] pos_reg;
    logic [10:0]   row_reg;
    logic          active_reg;
    logic          out_valid_reg;

    logic [1:0]    region;
    logic [10:0]   mask11;
    logic [9:0]    trow;
    logic          last;
    logic          emit;

    always_comb
    begin
        mask11 = (11'd1 << cfg.tex_log2) - 11'd1;
        trow   = pos_reg[PW-1:F] & mask11[9:0];
        last   = ({1'b0, row_reg} >= (cfg.height - 12'd1));
        if (row_reg < col_reg.top)
            region = REGION_CEILING;
        else if (row_reg > col_reg.bottom)
            region = REGION_FLOOR;
        else
            region = REGION_WALL;
    end

    assign row_pop = row_req && (!out_valid_reg || result.ready);
    // a row with no column set up is dropped
    assign emit    = row_pop && active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                active_reg <= 1'b1;
                row_reg    <= '0;
            end
            else if (emit)
            begin
                if (last)
                    active_reg <= 1'b0;
                else
                    row_reg <= row_reg + 11'd1;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_reg  <= col;
            step_reg <= step;
            pos_reg  <= pos;
        end
        else if (emit && region == REGION_WALL)
            pos_reg <= pos_reg + step_reg[PW-1:0];
        if (emit)
        begin
            result.out_column <= col_reg.column;
            result.row        <= row_reg;
            result.region     <= region;
            result.face       <= col_reg.face;
            result.tex_col    <= (region == REGION_WALL) ? col_reg.tex_col : 10'd0;
            result.tex_row    <= (region == REGION_WALL) ? trow : 10'd0;
            result.last_row   <= last;
        end
    end

    assign result.valid = out_valid_reg;

endmodule

FILE: design/raycast_wall_column_texcoord.sv
// setup beat: the shared one-bit-per-cycle divider (height, then texture step), then the
// serial start multiply
// row beat: one per cycle while the output side is ready and no setup runs, each result registered on acceptance
// a two-beat queue lets items be taken while setup or the output side stalls
// reset: screen height 480, texture width 64, texture height log2 6, no column active
module raycast_wall_column_texcoord #(
    parameter int FRACTION_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    rwc_item_if.sink      item,
    rwc_result_if.source  result,
    rwc_cfg_if.sink       cfg
);
    import rwc_pkg::*;

    logic [11:0] screen_height_reg;
    logic [10:0] texture_width_reg;
    logic [3:0]  texture_log2_reg;
    cfg_t        cfg_eff;

    cmd_t        head;
    logic        head_valid;
    logic        head_pop;
    logic        setup_start;
    logic        busy;
    logic        load;
    col_t        col;
    logic [FRACTION_BITS+10:0] step;
    logic [FRACTION_BITS+9:0]  pos;
    logic        row_req;
    logic        row_pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_height_reg <= 12'd480;
            texture_width_reg <= 11'd64;
            texture_log2_reg  <= 4'd6;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg.data;
                CFG_TEXTURE_WIDTH: texture_width_reg <= cfg.data[10:0];
                CFG_TEXTURE_LOG2:  texture_log2_reg  <= cfg.data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (screen_height_reg == 12'd0)
            cfg_eff.height = 12'd1;
        else if (screen_height_reg > 12'(MAX_SCREEN))
            cfg_eff.height = 12'(MAX_SCREEN);
        else
            cfg_eff.height = screen_height_reg;
        if (texture_width_reg == 11'd0)
            cfg_eff.width = 11'd1;
        else if (texture_width_reg > 11'(MAX_TEXW))
            cfg_eff.width = 11'(MAX_TEXW);
        else
            cfg_eff.width = texture_width_reg;
        cfg_eff.tex_log2 = (texture_log2_reg > 4'(MAX_TEXL)) ? 4'(MAX_TEXL) : texture_log2_reg;
    end

    rwc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    // rows wait until the column set up ahead of them is loaded
    assign setup_start = head_valid && !head.is_row && !busy;
    assign row_req     = head_valid && head.is_row && !busy;
    assign head_pop    = setup_start || row_pop;

    rwc_setup #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_setup (
        .clk   (clk),
        .rst_n (rst_n),
        .start (setup_start),
        .cmd   (head),
        .cfg   (cfg_eff),
        .busy  (busy),
        .load  (load),
        .col   (col),
        .step  (step),
        .pos   (pos)
    );

    rwc_rows #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_rows (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .col     (col),
        .step    (step),
        .pos     (pos),
        .cfg     (cfg_eff),
        .row_req (row_req),
        .row_pop (row_pop),
        .result  (result)
    );

endmodule
